// File: hw/rtl/uirf_pkg.sv
`default_nettype none

package uirf_pkg;

    // frame offsets of the fixed header fields (offset of the field's last byte)
    localparam logic [15:0] ETHERTYPE_END_OFF = 16'd13;
    localparam logic [15:0] VER_IHL_OFF       = 16'd14;
    localparam logic [15:0] PROTOCOL_OFF      = 16'd23;
    localparam logic [15:0] SRC_IP_END_OFF    = 16'd29;
    localparam logic [15:0] MIN_FRAME_LEN     = 16'd42;
    localparam logic [15:0] MAX_OFFSET        = 16'hFFFF;

    // udp header: port ends at +3, length ends at +5, payload starts at +8
    localparam logic [15:0] UDP_PORT_END_REL  = 16'd3;
    localparam logic [15:0] UDP_LEN_END_REL   = 16'd5;
    localparam logic [15:0] UDP_HDR_LEN       = 16'd8;

    localparam logic [6:0]  UDP_START_RESET   = 7'd34;
    localparam logic [6:0]  ETH_HDR_LEN       = 7'd14;

    localparam logic [15:0] ETHERTYPE_IPV4    = 16'h0800;
    localparam logic [7:0]  VERSION_MASK      = 8'hF0;
    localparam logic [7:0]  VERSION_IPV4      = 8'h40;
    localparam logic [7:0]  IHL_MASK          = 8'h0F;
    localparam logic [3:0]  IHL_MIN           = 4'd5;
    localparam logic [7:0]  PROTO_UDP         = 8'd17;

    // configuration register indexes
    localparam logic CFG_SOURCE_IP = 1'b0;
    localparam logic CFG_PORT      = 1'b1;

    // result queue
    localparam int unsigned OUT_DEPTH = 4;
    localparam int unsigned OUT_PTR_W = $clog2(OUT_DEPTH);
    localparam int unsigned OUT_CNT_W = $clog2(OUT_DEPTH + 1);

    typedef enum logic [3:0] {
        VERDICT_OK        = 4'd0,
        VERDICT_SHORT     = 4'd1,
        VERDICT_ETHERTYPE = 4'd2,
        VERDICT_VERSION   = 4'd3,
        VERDICT_NOT_UDP   = 4'd4,
        VERDICT_SOURCE    = 4'd5,
        VERDICT_PORT      = 4'd6,
        VERDICT_UDP_LEN   = 4'd7,
        VERDICT_TRUNCATED = 4'd8
    } verdict_t;

    typedef struct packed {
        logic       end_of_frame;
        logic [7:0] payload_byte;
        verdict_t   verdict;
    } result_t;

    // results caused by one byte, in order: first, then second
    typedef struct packed {
        logic [1:0] count;
        result_t    first;
        result_t    second;
    } result_pair_t;

endpackage

`default_nettype wire

// File: hw/rtl/uirf_parser.sv
`default_nettype none

module uirf_parser (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   in_fire,
    input  wire logic [7:0]             in_byte,
    input  wire logic                   in_last,
    input  wire logic [31:0]            source_ip_filter,
    input  wire logic [15:0]            port_filter,
    output uirf_pkg::result_pair_t      results
);
    import uirf_pkg::*;

    logic [15:0] byte_offset_reg, byte_offset_next;
    logic [6:0]  udp_start_reg, udp_start_next;
    logic [31:0] field_shift_reg, field_shift_next;
    logic [15:0] payload_rem_reg, payload_rem_next;
    verdict_t    pending_reg, pending_next;

    logic [15:0] off;
    logic [15:0] ustart_ext;
    logic [15:0] udp_len;
    logic [3:0]  ihl;
    logic        emit;
    logic [15:0] rem_after;
    verdict_t    final_verdict;
    result_t     byte_res;
    result_t     verdict_res;

    always_comb begin
        off              = byte_offset_reg;
        field_shift_next = {field_shift_reg[23:0], in_byte};
        udp_start_next   = udp_start_reg;
        pending_next     = pending_reg;
        payload_rem_next = payload_rem_reg;
        ihl              = in_byte[3:0] & IHL_MASK[3:0];
        udp_len          = field_shift_next[15:0];
        ustart_ext       = {9'd0, udp_start_reg};

        if (pending_reg == VERDICT_OK) begin
            priority if (off == ETHERTYPE_END_OFF) begin
                if (field_shift_next[15:0] != ETHERTYPE_IPV4) pending_next = VERDICT_ETHERTYPE;
            end else if (off == VER_IHL_OFF) begin
                if ((in_byte & VERSION_MASK) != VERSION_IPV4 || ihl < IHL_MIN)
                    pending_next = VERDICT_VERSION;
                else
                    udp_start_next = ETH_HDR_LEN + {1'b0, ihl, 2'b00};
            end else if (off == PROTOCOL_OFF) begin
                if (in_byte != PROTO_UDP) pending_next = VERDICT_NOT_UDP;
            end else if (off == SRC_IP_END_OFF) begin
                if (source_ip_filter != 32'd0 && field_shift_next != source_ip_filter)
                    pending_next = VERDICT_SOURCE;
            end else if (off == ustart_ext + UDP_PORT_END_REL) begin
                if (port_filter != 16'd0 && field_shift_next[15:0] != port_filter)
                    pending_next = VERDICT_PORT;
            end else if (off == ustart_ext + UDP_LEN_END_REL) begin
                if (udp_len < UDP_HDR_LEN)
                    pending_next = VERDICT_UDP_LEN;
                else
                    payload_rem_next = udp_len - UDP_HDR_LEN;
            end else begin
            end
        end

        // payload window; the start offset only moves long before it opens
        emit = (pending_next == VERDICT_OK)
            && (off >= {9'd0, udp_start_next} + UDP_HDR_LEN)
            && (payload_rem_next != 16'd0);
        rem_after = emit ? payload_rem_next - 16'd1 : payload_rem_next;

        // compared against length minus one so a saturated offset cannot wrap
        priority if (off < MIN_FRAME_LEN - 16'd1)
            final_verdict = VERDICT_SHORT;
        else if (pending_next != VERDICT_OK)
            final_verdict = pending_next;
        else if (off < {9'd0, udp_start_next} + UDP_LEN_END_REL || rem_after != 16'd0)
            final_verdict = VERDICT_TRUNCATED;
        else
            final_verdict = VERDICT_OK;

        byte_res.end_of_frame    = 1'b0;
        byte_res.payload_byte    = in_byte;
        byte_res.verdict         = VERDICT_OK;
        verdict_res.end_of_frame = 1'b1;
        verdict_res.payload_byte = 8'd0;
        verdict_res.verdict      = final_verdict;

        results.count  = 2'd0;
        results.first  = byte_res;
        results.second = verdict_res;
        if (in_fire) begin
            if (emit) begin
                results.count = in_last ? 2'd2 : 2'd1;
            end else if (in_last) begin
                results.count = 2'd1;
                results.first = verdict_res;
            end
        end

        if (in_last) begin
            byte_offset_next = 16'd0;
        end else if (byte_offset_reg != MAX_OFFSET) begin
            byte_offset_next = byte_offset_reg + 16'd1;
        end else begin
            byte_offset_next = byte_offset_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_offset_reg <= 16'd0;
            udp_start_reg   <= UDP_START_RESET;
            field_shift_reg <= 32'd0;
            payload_rem_reg <= 16'd0;
            pending_reg     <= VERDICT_OK;
        end else if (in_fire) begin
            if (in_last) begin
                byte_offset_reg <= 16'd0;
                udp_start_reg   <= UDP_START_RESET;
                field_shift_reg <= 32'd0;
                payload_rem_reg <= 16'd0;
                pending_reg     <= VERDICT_OK;
            end else begin
                byte_offset_reg <= byte_offset_next;
                udp_start_reg   <= udp_start_next;
                field_shift_reg <= field_shift_next;
                payload_rem_reg <= rem_after;
                pending_reg     <= pending_next;
            end
        end
    end

    // a frame end brings the offset back to the start
    a_offset_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        in_fire && in_last |=> byte_offset_reg == 16'd0)
        else $error("byte offset not cleared after frame end");

    // udp header lies between a 20 and a 60 byte ip header
    a_udp_start_range: assert property (@(posedge aclk) disable iff (!aresetn)
        udp_start_reg >= UDP_START_RESET && udp_start_reg <= 7'd74)
        else $error("udp start offset out of range");

    // payload never flows once a check has failed
    a_no_payload_after_fail: assert property (@(posedge aclk) disable iff (!aresetn)
        pending_reg != VERDICT_OK |-> !emit)
        else $error("payload byte after failed check");

endmodule

`default_nettype wire

// File: hw/rtl/uirf_out_queue.sv
`default_nettype none

module uirf_out_queue (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  uirf_pkg::result_pair_t      push,
    output logic                        room,
    output logic                        m_valid,
    input  wire logic                   m_ready,
    output uirf_pkg::result_t           head
);
    import uirf_pkg::*;

    result_t                mem [OUT_DEPTH];
    logic [OUT_PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [OUT_PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [OUT_CNT_W-1:0]   count_reg, count_next;
    logic                   pop;
    logic [OUT_PTR_W-1:0]   wr_ptr_plus1;

    assign m_valid      = count_reg != '0;
    assign head         = mem[rd_ptr_reg];
    assign pop          = m_valid && m_ready;
    assign room         = count_reg <= OUT_CNT_W'(OUT_DEPTH - 2);
    assign wr_ptr_plus1 = wr_ptr_reg + OUT_PTR_W'(1);

    always_comb begin
        wr_ptr_next = wr_ptr_reg + OUT_PTR_W'(push.count);
        rd_ptr_next = pop ? rd_ptr_reg + OUT_PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg + OUT_CNT_W'(push.count) - OUT_CNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (push.count != 2'd0) begin
            mem[wr_ptr_reg] <= push.first;
        end
        if (push.count == 2'd2) begin
            mem[wr_ptr_plus1] <= push.second;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_no_overfill: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= OUT_CNT_W'(OUT_DEPTH))
        else $error("result queue overfilled");

    a_push_has_room: assert property (@(posedge aclk) disable iff (!aresetn)
        push.count != 2'd0 |-> count_reg <= OUT_CNT_W'(OUT_DEPTH - 2))
        else $error("results pushed without room");

    a_ptr_match: assert property (@(posedge aclk) disable iff (!aresetn)
        OUT_PTR_W'(wr_ptr_reg - rd_ptr_reg) == count_reg[OUT_PTR_W-1:0])
        else $error("queue pointers disagree with fill count");

endmodule

`default_nettype wire

// File: hw/rtl/udp_ipv4_receive_filter_unit.sv
`default_nettype none

// udp over ipv4 receive filter. takes an ethernet frame one byte per transfer
// on s_ (s_last_byte marks the final byte) and checks ethertype 0x0800, ip
// version 4 with ihl of at least 5, protocol udp, an optional source address
// and an optional udp destination port (a filter value of 0 accepts any).
// while a frame passes, its udp payload bytes come out on m_ with
// m_end_of_frame low; each frame closes with one transfer carrying
// m_end_of_frame high and the verdict (0 ok, 1 short, 2 ethertype, 3 version
// or ihl, 4 not udp, 5 source, 6 port, 7 udp length, 8 truncated). frames
// under 42 bytes always report short. one byte is taken every clock: each
// byte is checked combinationally against the per-frame state and its
// results go into a four-entry result queue, so s_ready only drops when the
// queue has fewer than two free slots, i.e. when m_ready is held low. the
// filter registers are written through cfg_wr_en/cfg_index/cfg_data and
// should only be changed between frames.
module udp_ipv4_receive_filter_unit (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // byte input
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_frame_byte,
    input  wire logic        s_last_byte,
    // result output
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic             m_end_of_frame,
    output logic [7:0]       m_payload_byte,
    output logic [3:0]       m_verdict,
    // configuration writes
    input  wire logic        cfg_wr_en,
    input  wire logic        cfg_index,
    input  wire logic [31:0] cfg_data
);
    import uirf_pkg::*;

    logic [31:0]  source_ip_filter_reg;
    logic [15:0]  port_filter_reg;
    logic         in_fire;
    result_pair_t results;
    result_t      head;

    // filter registers, big-endian as the bytes arrive
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            source_ip_filter_reg <= 32'd0;
            port_filter_reg      <= 16'd0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_SOURCE_IP: source_ip_filter_reg <= cfg_data;
                CFG_PORT:      port_filter_reg      <= cfg_data[15:0];
                default: begin
                end
            endcase
        end
    end

    // a byte transfer happens whenever a byte is offered and the queue can take two results
    assign in_fire = s_valid && s_ready;

    // header checks and payload window, one byte per cycle while the queue has room
    uirf_parser u_parser (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .in_fire          (in_fire),
        .in_byte          (s_frame_byte),
        .in_last          (s_last_byte),
        .source_ip_filter (source_ip_filter_reg),
        .port_filter      (port_filter_reg),
        .results          (results)
    );

    // result queue parts the input side from a stalled output
    uirf_out_queue u_out_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (results),
        .room    (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .head    (head)
    );

    assign m_end_of_frame = head.end_of_frame;
    assign m_payload_byte = head.payload_byte;
    assign m_verdict      = head.verdict;

endmodule

`default_nettype wire

// File: verif/testbench.sv
module testbench;
    import uirf_pkg::*;

    // one directed frame: filter setting it runs under, header fields, sizes,
    // and the verdict where it can be stated outright
    typedef struct packed {
        logic [31:0] src_filter;
        logic [15:0] port_filter;
        logic [15:0] ethertype;
        logic [7:0]  ver_ihl;
        logic [7:0]  protocol;
        logic [31:0] src_ip;
        logic [15:0] udp_dport;
        logic [15:0] udp_length;
        logic [15:0] payload_n;
        logic [15:0] pad_n;
        logic [15:0] cut_at;      // 0 keeps the whole frame
        logic        fixed;       // verdict below is given, not predicted
        verdict_t    verdict;
    } frame_case_t;

    localparam logic [31:0] HOST_A = 32'hC0A8_0001;
    localparam logic [31:0] HOST_B = 32'h0A00_0002;

    // directed frames, walked in order
    localparam frame_case_t DIRECTED_FRAMES [25] = '{
        // smallest complete frame, no payload
        '{32'h0, 16'h0, ETHERTYPE_IPV4, 8'h45, PROTO_UDP, HOST_A, 16'd53, 16'd8, 16'd0,
          16'd0, 16'd0, 1'b1, VERDICT_OK},
        '{32'h0, 16'h0, ETHERTYPE_IPV4, 8'h45, PROTO_UDP, HOST_A, 16'd53, 16'd18, 16'd10,
          16'd0, 16'd0, 1'b0, VERDICT_OK},
        // one byte under the minimum, then a single-byte frame
        '{32'h0, 16'h0, ETHERTYPE_IPV4, 8'h45, PROTO_UDP, HOST_A, 16'd53, 16'd8, 16'd0,
          16'd0, 16'd41, 1'b1, VERDICT_SHORT},
        '{32'h0, 16'h0, ETHERTYPE_IPV4, 8'h45, PROTO_UDP, HOST_A, 16'd53, 16'd8, 16'd0,
          16'd0, 16'd1, 1'b1, VERDICT_SHORT},
        '{32'h0, 16'h0, 16'h86DD, 8'h45, PROTO_UDP, HOST_A, 16'd53, 16'd8, 16'd0,
          16'd0, 16'd0, 1'b1, VERDICT_ETHERTYPE},
        '{32'h0, 16'h0, ETHERTYPE_IPV4, 8'h65, PROTO_UDP, HOST_A, 16'd53, 16'd8, 16'd0,
          16'd0, 16'd0, 1'b1, VERDICT_VERSION},
        // ihl below five
        '{32'h0, 16'h0, ETHERTYPE_IPV4, 8'h44, PROTO_UDP, HOST_A, 16'd53, 16'd8, 16'd0,
          16'd0, 16'd0, 1'b1, VERDICT_VERSION},
        '{32'h0, 16'h0, ETHERTYPE_IPV4, 8'h40, PROTO_UDP, HOST_A, 16'd53, 16'd8, 16'd0,
          16'd0, 16'd0, 1'b1, VERDICT_VERSION},
        // largest ihl, udp header after 60 bytes of ip header
        '{32'h0, 16'h0, ETHERTYPE_IPV4, 8'h4F, PROTO_UDP, HOST_A, 16'd53, 16'd12, 16'd4,
          16'd0, 16'd0, 1'b0, VERDICT_OK},
        '{32'h0, 16'h0, ETHERTYPE_IPV4, 8'h45, 8'd6, HOST_A, 16'd53, 16'd8, 16'd0,
          16'd0, 16'd0, 1'b1, VERDICT_NOT_UDP},
        // udp length below the header size
        '{32'h0, 16'h0, ETHERTYPE_IPV4, 8'h45, PROTO_UDP, HOST_A, 16'd53, 16'd7, 16'd0,
          16'd4, 16'd0, 1'b1, VERDICT_UDP_LEN},
        '{32'h0, 16'h0, ETHERTYPE_IPV4, 8'h45, PROTO_UDP, HOST_A, 16'd53, 16'd0, 16'd0,
          16'd4, 16'd0, 1'b1, VERDICT_UDP_LEN},
        // payload runs past the frame end, bytes already out stay out
        '{32'h0, 16'h0, ETHERTYPE_IPV4, 8'h45, PROTO_UDP, HOST_A, 16'd53, 16'hFFFF, 16'd30,
          16'd0, 16'd0, 1'b1, VERDICT_TRUNCATED},
        // frame ends before the udp length field
        '{32'h0, 16'h0, ETHERTYPE_IPV4, 8'h4F, PROTO_UDP, HOST_A, 16'd53, 16'd20, 16'd12,
          16'd0, 16'd60, 1'b1, VERDICT_TRUNCATED},
        // padding after the payload is ignored
        '{32'h0, 16'h0, ETHERTYPE_IPV4, 8'h45, PROTO_UDP, HOST_A, 16'd53, 16'd10, 16'd2,
          16'd30, 16'd0, 1'b0, VERDICT_OK},
        // earliest failing check wins, short wins over everything
        '{32'h0, 16'h0, 16'h0000, 8'h45, 8'd6, HOST_A, 16'd53, 16'd8, 16'd0,
          16'd0, 16'd0, 1'b1, VERDICT_ETHERTYPE},
        '{32'h0, 16'h0, 16'h0000, 8'h45, PROTO_UDP, HOST_A, 16'd53, 16'd8, 16'd0,
          16'd0, 16'd20, 1'b1, VERDICT_SHORT},
        '{32'h0, 16'h0, ETHERTYPE_IPV4, 8'hFF, 8'd0, HOST_A, 16'd53, 16'd0, 16'd0,
          16'd0, 16'd0, 1'b1, VERDICT_VERSION},
        // source and port filters
        '{HOST_A, 16'h0, ETHERTYPE_IPV4, 8'h45, PROTO_UDP, HOST_A, 16'd53, 16'd11, 16'd3,
          16'd0, 16'd0, 1'b0, VERDICT_OK},
        '{HOST_A, 16'h0, ETHERTYPE_IPV4, 8'h45, PROTO_UDP, HOST_B, 16'd53, 16'd11, 16'd3,
          16'd0, 16'd0, 1'b1, VERDICT_SOURCE},
        '{32'hFFFF_FFFF, 16'hFFFF, ETHERTYPE_IPV4, 8'h45, PROTO_UDP, 32'hFFFF_FFFF,
          16'hFFFF, 16'd9, 16'd1, 16'd0, 16'd0, 1'b0, VERDICT_OK},
        '{32'h0, 16'h0035, ETHERTYPE_IPV4, 8'h45, PROTO_UDP, HOST_A, 16'h0036, 16'd8, 16'd0,
          16'd0, 16'd0, 1'b1, VERDICT_PORT},
        '{HOST_A, 16'h0035, ETHERTYPE_IPV4, 8'h45, PROTO_UDP, HOST_B, 16'h0036, 16'd8, 16'd0,
          16'd0, 16'd0, 1'b1, VERDICT_SOURCE},
        '{32'h1, 16'h1, ETHERTYPE_IPV4, 8'h45, PROTO_UDP, 32'h1, 16'h1, 16'd8, 16'd0,
          16'd0, 16'd0, 1'b0, VERDICT_OK},
        // long frame: byte offset saturates, largest udp length
        '{32'h0, 16'h0, ETHERTYPE_IPV4, 8'h4F, PROTO_UDP, HOST_A, 16'd53, 16'hFFFF, 16'd65527,
          16'd300, 16'd0, 1'b0, VERDICT_OK}
    };

    // filter settings of the random phases; the last phase draws its own
    localparam logic [31:0] PHASE_SRC  [4] = '{32'h0, 32'hFFFF_FFFF, 32'h0, 32'h1};
    localparam logic [15:0] PHASE_PORT [4] = '{16'h0, 16'h0, 16'hFFFF, 16'h1};
    localparam int unsigned PHASE_BYTES = 380;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_frame_byte = 8'h00;
    logic        s_last_byte = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic        m_end_of_frame;
    logic [7:0]  m_payload_byte;
    logic [3:0]  m_verdict;
    logic        cfg_wr_en = 1'b0;
    logic        cfg_index = CFG_SOURCE_IP;
    logic [31:0] cfg_data = 32'h0;

    // results still owed by the block, oldest first
    result_t     awaited_results[$];
    logic [7:0]  frame_bytes[$];
    int unsigned mismatches = 0;
    // while set, neither side inserts idle cycles
    bit          calm_stretch = 1'b0;

    // the bench's model of the filter's registers and per-frame state
    logic [31:0] want_src_ip;
    logic [15:0] want_udp_dport;
    logic [15:0] rx_offset;
    logic [6:0]  udp_base;
    logic [31:0] recent_bytes;
    logic [15:0] udp_len_field;
    logic [15:0] payload_left;
    verdict_t    first_fault;

    udp_ipv4_receive_filter_unit dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_frame_byte   (s_frame_byte),
        .s_last_byte    (s_last_byte),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_end_of_frame (m_end_of_frame),
        .m_payload_byte (m_payload_byte),
        .m_verdict      (m_verdict),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    always #5 aclk = ~aclk;

    function automatic void clear_frame_state();
        rx_offset     = 16'h0;
        udp_base      = UDP_START_RESET;
        recent_bytes  = 32'h0;
        udp_len_field = 16'h0;
        payload_left  = 16'h0;
        first_fault   = VERDICT_OK;
    endfunction

    // advance the filter by one accepted byte and queue what it owes for it
    function automatic void track_frame_byte(input logic [7:0] b, input logic last);
        int unsigned off;
        int unsigned base;
        result_t     r;
        verdict_t    v;
        off  = rx_offset;
        base = udp_base;
        recent_bytes = {recent_bytes[23:0], b};
        // header checks by offset; the first failure sticks
        if (first_fault == VERDICT_OK) begin
            if (off == ETHERTYPE_END_OFF) begin
                if (recent_bytes[15:0] != ETHERTYPE_IPV4)
                    first_fault = VERDICT_ETHERTYPE;
            end else if (off == VER_IHL_OFF) begin
                if ((b & VERSION_MASK) != VERSION_IPV4 || b[3:0] < IHL_MIN)
                    first_fault = VERDICT_VERSION;
                else
                    udp_base = ETH_HDR_LEN + {1'b0, b[3:0], 2'b00};
            end else if (off == PROTOCOL_OFF) begin
                if (b != PROTO_UDP)
                    first_fault = VERDICT_NOT_UDP;
            end else if (off == SRC_IP_END_OFF) begin
                if (want_src_ip != 32'h0 && recent_bytes != want_src_ip)
                    first_fault = VERDICT_SOURCE;
            end else if (off == base + UDP_PORT_END_REL) begin
                if (want_udp_dport != 16'h0 && recent_bytes[15:0] != want_udp_dport)
                    first_fault = VERDICT_PORT;
            end else if (off == base + UDP_LEN_END_REL) begin
                udp_len_field = recent_bytes[15:0];
                if (udp_len_field < UDP_HDR_LEN)
                    first_fault = VERDICT_UDP_LEN;
                else
                    payload_left = udp_len_field - UDP_HDR_LEN;
            end
        end
        // payload byte goes out while the frame is clean
        if (first_fault == VERDICT_OK && off >= base + UDP_HDR_LEN && payload_left != 0) begin
            r.end_of_frame = 1'b0;
            r.payload_byte = b;
            r.verdict      = VERDICT_OK;
            awaited_results.push_back(r);
            payload_left--;
        end
        if (last) begin
            if (off + 1 < MIN_FRAME_LEN)
                v = VERDICT_SHORT;
            else if (first_fault != VERDICT_OK)
                v = first_fault;
            else if (off < base + UDP_LEN_END_REL || payload_left != 0)
                v = VERDICT_TRUNCATED;
            else
                v = VERDICT_OK;
            r.end_of_frame = 1'b1;
            r.payload_byte = 8'h00;
            r.verdict      = v;
            awaited_results.push_back(r);
            clear_frame_state();
        end else if (rx_offset != MAX_OFFSET) begin
            rx_offset++;
        end
    endfunction

    // lay out an ethernet/ipv4/udp frame; fields not under test are random
    task automatic build_frame(input frame_case_t c);
        frame_bytes.delete();
        repeat (12) frame_bytes.push_back(8'($urandom()));
        frame_bytes.push_back(c.ethertype[15:8]);
        frame_bytes.push_back(c.ethertype[7:0]);
        frame_bytes.push_back(c.ver_ihl);
        // tos, total length, id, fragment, ttl
        repeat (8) frame_bytes.push_back(8'($urandom()));
        frame_bytes.push_back(c.protocol);
        repeat (2) frame_bytes.push_back(8'($urandom()));
        for (int i = 3; i >= 0; i--)
            frame_bytes.push_back(c.src_ip[8 * i +: 8]);
        repeat (4) frame_bytes.push_back(8'($urandom()));
        // ip options
        if (c.ver_ihl[3:0] > 4'd5)
            repeat ((c.ver_ihl[3:0] - 5) * 4) frame_bytes.push_back(8'($urandom()));
        repeat (2) frame_bytes.push_back(8'($urandom()));
        frame_bytes.push_back(c.udp_dport[15:8]);
        frame_bytes.push_back(c.udp_dport[7:0]);
        frame_bytes.push_back(c.udp_length[15:8]);
        frame_bytes.push_back(c.udp_length[7:0]);
        repeat (2) frame_bytes.push_back(8'($urandom()));
        repeat (c.payload_n) frame_bytes.push_back(8'($urandom()));
        repeat (c.pad_n) frame_bytes.push_back(8'($urandom()));
        if (c.cut_at != 0)
            while (frame_bytes.size() > c.cut_at)
                void'(frame_bytes.pop_back());
    endtask

    // mostly well-formed frames that match the filters, a share broken in one place
    function automatic frame_case_t random_case();
        frame_case_t c;
        int unsigned hdr;
        int unsigned pick;
        c = '0;
        c.ethertype = ETHERTYPE_IPV4;
        c.ver_ihl   = ($urandom_range(0, 3) == 0) ? {4'h4, 4'($urandom_range(5, 15))} : 8'h45;
        c.protocol  = PROTO_UDP;
        c.src_ip    = (want_src_ip != 0 && $urandom_range(0, 3) != 0) ?
                      want_src_ip : $urandom();
        c.udp_dport = (want_udp_dport != 0 && $urandom_range(0, 3) != 0) ?
                      want_udp_dport : 16'($urandom());
        c.payload_n = ($urandom_range(0, 15) == 0) ? 16'($urandom_range(25, 200)) :
                      16'($urandom_range(0, 24));
        c.udp_length = c.payload_n + UDP_HDR_LEN;
        hdr = 4 * c.ver_ihl[3:0] + 14 + 8;
        c.pad_n = 16'(((hdr + c.payload_n < 42) ? 42 - hdr - c.payload_n : 0)
                      + $urandom_range(0, 6));
        pick = $urandom_range(0, 99);
        if (pick < 8)
            c.ethertype = 16'($urandom());
        else if (pick < 16)
            c.ver_ihl = 8'($urandom());
        else if (pick < 24)
            c.protocol = 8'($urandom());
        else if (pick < 30)
            c.udp_length = 16'($urandom_range(0, 9));
        else if (pick < 36)
            c.udp_length = c.udp_length + 16'($urandom_range(1, 40));
        else if (pick < 44)
            c.cut_at = 16'($urandom_range(1, hdr + c.payload_n + c.pad_n - 1));
        return c;
    endfunction

    // offer one byte and hold it until the transfer happens
    task automatic send_byte(input logic [7:0] b, input logic last);
        int unsigned gap;
        gap = calm_stretch ? 0 : $urandom_range(0, 17);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_frame_byte <= b;
        s_last_byte  <= last;
        do @(posedge aclk); while (s_ready !== 1'b1);
        track_frame_byte(b, last);
    endtask

    task automatic send_frame(input logic fixed, input verdict_t verdict);
        for (int i = 0; i < frame_bytes.size(); i++)
            send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
        // the verdict of the last byte is still queued: replace it by the stated one
        if (fixed && awaited_results.size() != 0)
            awaited_results[awaited_results.size() - 1].verdict = verdict;
    endtask

    // stop sending, let every owed result drain, then a few quiet cycles
    task automatic settle();
        s_valid <= 1'b0;
        while (awaited_results.size() != 0) @(posedge aclk);
        repeat (16) @(posedge aclk);
    endtask

    // both filter registers, on back-to-back edges, only while idle
    task automatic program_filters(input logic [31:0] src, input logic [15:0] port);
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_SOURCE_IP;
        cfg_data  <= src;
        @(posedge aclk);
        cfg_index <= CFG_PORT;
        cfg_data  <= {16'h0000, port};
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        want_src_ip    = src;
        want_udp_dport = port;
    endtask

    // result side: random stall per transfer, each transfer checked against the oldest
    // owed result
    initial begin
        result_t     want;
        int unsigned stall;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            stall = calm_stretch ? 0 : $urandom_range(0, 17);
            if (stall != 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (m_valid !== 1'b1);
            if (awaited_results.size() == 0) begin
                $display("%0t: expected no result, got eof %b byte %h verdict %0d",
                         $time, m_end_of_frame, m_payload_byte, m_verdict);
                mismatches++;
            end else begin
                want = awaited_results.pop_front();
                if (m_end_of_frame !== want.end_of_frame) begin
                    $display("%0t: end_of_frame expected %b got %b",
                             $time, want.end_of_frame, m_end_of_frame);
                    mismatches++;
                end
                if (m_payload_byte !== want.payload_byte) begin
                    $display("%0t: payload_byte expected %h got %h",
                             $time, want.payload_byte, m_payload_byte);
                    mismatches++;
                end
                if (m_verdict !== want.verdict) begin
                    $display("%0t: verdict expected %0d got %0d",
                             $time, want.verdict, m_verdict);
                    mismatches++;
                end
            end
        end
    end

    // byte side: reset, directed frames, then random phases under several filter settings
    initial begin
        frame_case_t fc;
        int unsigned phase_bytes;
        int unsigned n;
        want_src_ip    = 32'h0;
        want_udp_dport = 16'h0;
        clear_frame_state();
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int k = 0; k < 25; k++) begin
            fc = DIRECTED_FRAMES[k];
            if (fc.src_filter != want_src_ip || fc.port_filter != want_udp_dport) begin
                settle();
                program_filters(fc.src_filter, fc.port_filter);
            end
            // the saturating frame runs flat out on both sides
            calm_stretch = (fc.payload_n + fc.pad_n > 1000);
            build_frame(fc);
            send_frame(fc.fixed, fc.verdict);
        end

        for (int p = 0; p < 5; p++) begin
            // sender holds off until the block has drained
            settle();
            if (p == 4)
                program_filters($urandom(), 16'($urandom_range(1, 65535)));
            else
                program_filters(PHASE_SRC[p], PHASE_PORT[p]);
            phase_bytes = 0;
            while (phase_bytes < PHASE_BYTES) begin
                calm_stretch = ($urandom_range(0, 4) == 0);
                if ($urandom_range(0, 99) < 15) begin
                    // noise, sometimes with a plausible header to get further in
                    n = $urandom_range(1, 70);
                    frame_bytes.delete();
                    repeat (n) frame_bytes.push_back(8'($urandom()));
                    if (n > 23 && $urandom_range(0, 1) == 1) begin
                        frame_bytes[12] = ETHERTYPE_IPV4[15:8];
                        frame_bytes[13] = ETHERTYPE_IPV4[7:0];
                        frame_bytes[14] = 8'h45;
                        frame_bytes[23] = PROTO_UDP;
                    end
                end else begin
                    build_frame(random_case());
                end
                phase_bytes += frame_bytes.size();
                send_frame(1'b0, VERDICT_OK);
            end
        end

        calm_stretch = 1'b0;
        settle();
        repeat (40) @(posedge aclk);
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // watchdog, several times the slowest legal run including the saturating frame
    initial begin
        #20_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule
